// ===== rtl/crspl_pkg.sv =====
// Shared types, widths and arithmetic helpers of the Catmull-Rom spline evaluator.
// Used by catmull_rom_spline_evaluator_unit; depends on nothing.
`default_nettype none

package crspl_pkg;

  // store geometry
  localparam int MAX_POINTS = 16;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int PT_W       = 32;
  localparam int ENTRY_W    = 2 * PT_W;

  // datapath widths
  localparam int TAU_W  = 17;
  localparam int ACC_W  = 44;
  localparam int WIDE_W = ACC_W + 2 * CNT_W + 1;
  localparam int OUT_W  = 48;
  localparam int ONE_Q16 = 65536;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_EVAL = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_EVAL  = 3'd0,
    ST_ADDED = 3'd1,
    ST_FULL  = 3'd2,
    ST_FEW   = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  typedef struct packed {
    logic                    req_type;
    logic signed [PT_W-1:0]  point_x;
    logic signed [PT_W-1:0]  point_y;
    logic [TAU_W-1:0]        tau;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic signed [OUT_W-1:0] slope_x;
    logic signed [OUT_W-1:0] slope_y;
    logic signed [OUT_W-1:0] bend_x;
    logic signed [OUT_W-1:0] bend_y;
    status_e                 status;
  } out_t;

  // s * u / 65536, rounded half up
  function automatic logic signed [ACC_W-1:0] mul_u(input logic signed [ACC_W-1:0] s,
                                                   input logic [TAU_W-1:0] u);
    logic signed [ACC_W+TAU_W:0] p;
    p = s * $signed({1'b0, u});
    p = p + $signed((ACC_W + TAU_W + 1)'(32768));
    return ACC_W'(p >>> 16);
  endfunction

  // halve with rounding half up, then clamp to the signed output range
  function automatic logic signed [OUT_W-1:0] half_sat(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] h;
    logic [WIDE_W-OUT_W:0]    hi;
    h  = (v + $signed(WIDE_W'(1))) >>> 1;
    hi = h[WIDE_W-1:OUT_W-1];
    if ((&hi) || !(|hi)) begin
      return h[OUT_W-1:0];
    end else if (h[WIDE_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/catmull_rom_spline_evaluator_unit.sv =====
// Catmull-Rom spline evaluator top level: point store, segment pick and Hermite datapath.
// Depends on crspl_pkg and crspl_ram.
//
// Takes one word per cycle while no output word is held, add or evaluate, and returns
// one result word for each, in order. The result word passes stages 1 to 5 and the
// output register and can be taken when the output side is ready. The control
// points are kept in four identical RAM copies so that the four neighbors of a
// segment are read in the same cycle; every add that finds the store not full writes
// all copies. A held output word freezes all stages, so input ready drops whenever
// an output word waits, however many stages hold items. Position, slope and bend come
// from a Horner chain of up to three registered multiply steps; values are Q32.16, saturated to 48 bits.
`default_nettype none

module catmull_rom_spline_evaluator_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire crspl_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output crspl_pkg::out_t      out_data_o
);

  localparam int CntW  = crspl_pkg::CNT_W;
  localparam int AddrW = crspl_pkg::ADDR_W;
  localparam int AccW  = crspl_pkg::ACC_W;
  localparam int WideW = crspl_pkg::WIDE_W;
  localparam int TauW  = crspl_pkg::TAU_W;
  localparam int PtW   = crspl_pkg::PT_W;
  localparam int ScW   = TauW + CntW;

  // global advance
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  logic accept;
  assign accept = in_valid_i && en;

  // point count
  logic [CntW-1:0] count_q;
  logic            add_ok;
  assign add_ok = accept && (in_data_i.req_type == crspl_pkg::REQ_ADD) &&
                  (count_q < CntW'(crspl_pkg::MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (add_ok) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // segment pick and status at acceptance
  logic [CntW-1:0]  m0;
  logic [ScW-1:0]   scaled;
  logic [ScW-1:0]   seg_raw;
  logic [CntW-1:0]  seg;
  logic [TauW-1:0]  u0;
  logic             prev0, next0;
  crspl_pkg::status_e status0;

  always_comb begin
    m0      = count_q - CntW'(1);
    scaled  = ScW'(in_data_i.tau) * ScW'(m0);
    seg_raw = (scaled - ScW'(1)) >> 16;
    seg     = (scaled == '0) ? '0 : CntW'(seg_raw);
    if (seg > m0 - CntW'(1)) begin
      seg = m0 - CntW'(1);
    end
    u0    = TauW'(scaled - (ScW'(seg) << 16));
    prev0 = (seg != '0);
    next0 = ({1'b0, seg} + (CntW + 1)'(2)) < {1'b0, count_q};
    if (in_data_i.req_type == crspl_pkg::REQ_ADD) begin
      status0 = (count_q < CntW'(crspl_pkg::MAX_POINTS)) ? crspl_pkg::ST_ADDED
                                                        : crspl_pkg::ST_FULL;
    end else if (count_q < CntW'(2)) begin
      status0 = crspl_pkg::ST_FEW;
    end else if (in_data_i.tau > TauW'(crspl_pkg::ONE_Q16)) begin
      status0 = crspl_pkg::ST_RANGE;
    end else begin
      status0 = crspl_pkg::ST_EVAL;
    end
  end

  // store copies, read at seg-1, seg, seg+1, seg+2
  logic [crspl_pkg::ENTRY_W-1:0] rd [4];
  logic [AddrW-1:0]              raddr [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      raddr[k] = AddrW'(seg + CntW'(k) - CntW'(1));
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_store
    crspl_ram #(
      .WIDTH (crspl_pkg::ENTRY_W),
      .DEPTH (crspl_pkg::MAX_POINTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (add_ok),
      .waddr_i (AddrW'(count_q)),
      .wdata_i ({in_data_i.point_y, in_data_i.point_x}),
      .re_i    (en),
      .raddr_i (raddr[k]),
      .rdata_o (rd[k])
    );
  end

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // stage 1: item info beside the RAM read
  crspl_pkg::status_e st1_q;
  logic [TauW-1:0]    u1_q;
  logic [CntW-1:0]    m1_q;
  logic               prev1_q, next1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q   <= status0;
      u1_q    <= u0;
      m1_q    <= m0;
      prev1_q <= prev0;
      next1_q <= next0;
    end
  end

  // stage 2: Hermite coefficients per axis
  logic signed [AccW-1:0] a1_d [2], a2_d [2], a3_d [2], p0_d [2];
  logic signed [AccW-1:0] a1_2q [2], a2_2q [2], a3_2q [2], p0_2q [2];
  crspl_pkg::status_e     st2_q;
  logic [TauW-1:0]        u2_q;
  logic [CntW-1:0]        m2_q;
  logic [2*CntW-1:0]      mm2_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic signed [AccW-1:0] pm, p0, p1, p2, df, d0, d1;
      pm = AccW'($signed(rd[0][PtW*k +: PtW]));
      p0 = AccW'($signed(rd[1][PtW*k +: PtW]));
      p1 = AccW'($signed(rd[2][PtW*k +: PtW]));
      p2 = AccW'($signed(rd[3][PtW*k +: PtW]));
      df = p1 - p0;
      d0 = prev1_q ? (p1 - pm) : '0;
      d1 = next1_q ? (p2 - p0) : '0;
      a1_d[k] = d0;
      a2_d[k] = (df <<< 2) + (df <<< 1) - (d1 + (d0 <<< 1));
      a3_d[k] = d1 + d0 - (df <<< 2);
      p0_d[k] = p0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_2q  <= a1_d;
      a2_2q  <= a2_d;
      a3_2q  <= a3_d;
      p0_2q  <= p0_d;
      st2_q  <= st1_q;
      u2_q   <= u1_q;
      m2_q   <= m1_q;
      mm2_q  <= (2 * CntW)'(m1_q) * (2 * CntW)'(m1_q);
    end
  end

  // stage 3: first Horner step of position, slope and bend
  logic signed [AccW-1:0] pt3_q [2], sl3_q [2], bd3_q [2], a1_3q [2], p0_3q [2];
  crspl_pkg::status_e     st3_q;
  logic [TauW-1:0]        u3_q;
  logic [CntW-1:0]        m3_q;
  logic [2*CntW-1:0]      mm3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        pt3_q[k] <= crspl_pkg::mul_u(a3_2q[k], u2_q) + a2_2q[k];
        sl3_q[k] <= crspl_pkg::mul_u((a3_2q[k] <<< 1) + a3_2q[k], u2_q) + (a2_2q[k] <<< 1);
        bd3_q[k] <= crspl_pkg::mul_u((a3_2q[k] <<< 2) + (a3_2q[k] <<< 1), u2_q) +
                    (a2_2q[k] <<< 1);
      end
      a1_3q <= a1_2q;
      p0_3q <= p0_2q;
      st3_q <= st2_q;
      u3_q  <= u2_q;
      m3_q  <= m2_q;
      mm3_q <= mm2_q;
    end
  end

  // stage 4: second Horner step, bend scaled by (n-1)^2
  logic signed [AccW-1:0]  pt4_q [2], sl4_q [2], p0_4q [2];
  logic signed [WideW-1:0] bd4_q [2];
  logic signed [WideW-1:0] mm_s;
  crspl_pkg::status_e      st4_q;
  logic [TauW-1:0]         u4_q;
  logic [CntW-1:0]         m4_q;

  assign mm_s = WideW'(mm3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        pt4_q[k] <= crspl_pkg::mul_u(pt3_q[k], u3_q) + a1_3q[k];
        sl4_q[k] <= crspl_pkg::mul_u(sl3_q[k], u3_q) + a1_3q[k];
        bd4_q[k] <= WideW'(bd3_q[k]) * mm_s;
      end
      p0_4q <= p0_3q;
      st4_q <= st3_q;
      u4_q  <= u3_q;
      m4_q  <= m3_q;
    end
  end

  // stage 5: last position step, slope scaled by n-1
  logic signed [AccW-1:0]  pt5_q [2];
  logic signed [WideW-1:0] sl5_q [2], bd5_q [2];
  logic signed [WideW-1:0] m_s;
  crspl_pkg::status_e      st5_q;

  assign m_s = WideW'(m4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        pt5_q[k] <= crspl_pkg::mul_u(pt4_q[k], u4_q) + (p0_4q[k] <<< 1);
        sl5_q[k] <= WideW'(sl4_q[k]) * m_s;
      end
      bd5_q <= bd4_q;
      st5_q <= st4_q;
    end
  end

  // output word: halve, saturate, zero the values unless evaluated
  crspl_pkg::out_t out_d, out_q;

  always_comb begin
    out_d = '0;
    out_d.status = st5_q;
    if (st5_q == crspl_pkg::ST_EVAL) begin
      out_d.pos_x   = crspl_pkg::half_sat(WideW'(pt5_q[0]));
      out_d.pos_y   = crspl_pkg::half_sat(WideW'(pt5_q[1]));
      out_d.slope_x = crspl_pkg::half_sat(sl5_q[0]);
      out_d.slope_y = crspl_pkg::half_sat(sl5_q[1]);
      out_d.bend_x  = crspl_pkg::half_sat(bd5_q[0]);
      out_d.bend_y  = crspl_pkg::half_sat(bd5_q[1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(crspl_pkg::MAX_POINTS))
    else $error("point count above store depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted add did not bump point count");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(v5_q))
    else $error("pipeline moved while output held");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != crspl_pkg::ST_EVAL |->
      out_data_o.pos_x == '0 && out_data_o.slope_y == '0 && out_data_o.bend_x == '0)
    else $error("non-evaluate word carries values");

  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline frozen");

endmodule

`default_nettype wire

// ===== rtl/crspl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; one instance per copy of the control point store.
`default_nettype none

module crspl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
